FILE: rtl/hcpp_pkg.sv
// Package: shared widths, datapath operation codes, controller states and handshake structs.
`default_nettype none
package hcpp_pkg;

  localparam int unsigned RegionCountW = 16;
  localparam int unsigned WordsW       = 27;
  localparam int unsigned OffsetW      = 26;
  localparam int unsigned ProdW        = 43;
  localparam int unsigned SmallW       = 42;
  localparam int unsigned CumW         = 44;
  localparam int unsigned ChunksW      = 18;
  localparam int unsigned GroupW       = 4;
  localparam int unsigned IndexW       = 3;
  localparam int unsigned ShiftW       = 3;
  localparam int unsigned TotalW       = 43;
  localparam int unsigned ResultSlots  = 8;
  localparam logic [WordsW-1:0] SmallestReset = 27'd4096;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMIT_ERR,
    OP_MUL_TOT,
    OP_MUL_CUR,
    OP_MUL_SMALL,
    OP_CG_STEP,
    OP_CG_FIN,
    OP_CC_INIT,
    OP_CC_SUB,
    OP_CC_ZERO,
    OP_DIV_LW,
    OP_DIV_LS,
    OP_CC_SUM,
    OP_EM_INIT,
    OP_EMIT,
    OP_DIV_T,
    OP_EM_UPD
  } dp_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_CUR,
    ST_MUL_SMALL,
    ST_GRP,
    ST_GRP_FIN,
    ST_CHK_INIT,
    ST_CHK,
    ST_CHK_DIVW,
    ST_CHK_DIVS,
    ST_CHK_WAIT,
    ST_EM_INIT,
    ST_EMIT,
    ST_EM_DIV,
    ST_EM_WAIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_low;     // region count below two
    logic grp_go;        // another full group fits under the cap
    logic cur_le_small;  // current span at or below the smallest span
    logic left_zero;
    logic cur_le_left;
    logic k_last;        // the next counted group is the last planned one
    logic div_done;
    logic i_last;        // the current emitted group is the last
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/hcpp_divider.sv
// Restoring radix-2 divider: one quotient bit per cycle, zero divisor yields zero.
`default_nettype none
module hcpp_divider (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [hcpp_pkg::ProdW-1:0]     dividend_i,
  input  wire logic [hcpp_pkg::WordsW-1:0]    divisor_i,
  output logic                                done_o,
  output logic [hcpp_pkg::ProdW-1:0]          quotient_o,
  output logic [hcpp_pkg::WordsW-1:0]         remainder_o
);

  localparam int unsigned Steps = hcpp_pkg::ProdW;
  localparam int unsigned CntW  = $clog2(Steps);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          zero_q, zero_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [hcpp_pkg::ProdW-1:0]    quot_q, quot_d;
  logic [hcpp_pkg::WordsW-1:0]   rem_q, rem_d;
  logic [hcpp_pkg::WordsW-1:0]   dvs_q, dvs_d;
  logic [hcpp_pkg::WordsW:0]     trial;
  logic                          fits;

  // Shift in the next dividend bit and trial-subtract.
  assign trial = {rem_q, quot_q[hcpp_pkg::ProdW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      zero_d = (divisor_i == '0);
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[hcpp_pkg::ProdW-2:0], fits};
      rem_d  = fits ? hcpp_pkg::WordsW'(trial - {1'b0, dvs_q})
                    : trial[hcpp_pkg::WordsW-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = zero_q ? '0 : quot_q;
  assign remainder_o = zero_q ? '0 : rem_q;

endmodule
`default_nettype wire

FILE: rtl/hcpp_datapath.sv
// Datapath: request registers, shared multiplier, group and chunk counting, result registers.
`default_nettype none
module hcpp_datapath #(
  parameter int unsigned GroupCap = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hcpp_pkg::dp_cmd_t                   cmd_i,
  output hcpp_pkg::dp_status_t                     status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [hcpp_pkg::WordsW-1:0]         cfg_data_i,
  input  wire logic [hcpp_pkg::RegionCountW-1:0]   region_count_i,
  input  wire logic [hcpp_pkg::WordsW-1:0]         region_words_i,
  output logic                                     valid_o,
  output logic [hcpp_pkg::IndexW-1:0]              group_index_o,
  output logic [hcpp_pkg::RegionCountW-1:0]        first_region_o,
  output logic [hcpp_pkg::OffsetW-1:0]             start_offset_words_o,
  output logic [hcpp_pkg::WordsW-1:0]              chunk_words_o,
  output logic [hcpp_pkg::GroupW-1:0]              group_count_o,
  output logic [hcpp_pkg::TotalW-1:0]              total_chunks_o,
  output logic                                     result_status_o,
  output logic                                     last_o
);

  localparam logic [hcpp_pkg::GroupW-1:0] CapW = hcpp_pkg::GroupW'(GroupCap);

  hcpp_pkg::dp_op_e op;

  logic [hcpp_pkg::WordsW-1:0]       smallest_q;
  logic [hcpp_pkg::RegionCountW-1:0] r_q;
  logic [hcpp_pkg::WordsW-1:0]       w_q;
  logic [hcpp_pkg::ProdW-1:0]        total_q, cur_q, span0_q, left_q, span_q, tc_q;
  logic [hcpp_pkg::SmallW-1:0]       small_q;
  logic [hcpp_pkg::CumW-1:0]         cum_q;
  logic [hcpp_pkg::GroupW-1:0]       ng_q, k_q, i_q;
  logic [hcpp_pkg::ChunksW-1:0]      chunks_q;
  logic [hcpp_pkg::ShiftW-1:0]       j_q;
  logic [hcpp_pkg::RegionCountW-1:0] region_q;
  logic [hcpp_pkg::WordsW-1:0]       off_q;
  logic [hcpp_pkg::RegionCountW-2:0] gs;

  logic [hcpp_pkg::WordsW-1:0]       mul_a;
  logic [hcpp_pkg::RegionCountW-1:0] mul_b;
  logic [hcpp_pkg::ProdW-1:0]        mul_p;

  logic                              div_start, div_done;
  logic [hcpp_pkg::ProdW-1:0]        div_dividend, div_quot;
  logic [hcpp_pkg::WordsW-1:0]       div_divisor, div_rem;

  logic                              grp_go, cur_le_small, k_last, i_last;
  logic                              valid_q;

  assign op = cmd_i.op;
  assign gs = r_q[hcpp_pkg::RegionCountW-1:1];

  // Status toward the controller.
  assign grp_go = (ng_q < CapW) &&
                  ((cum_q + {1'b0, cur_q}) <= {1'b0, total_q});
  assign cur_le_small = cur_q <= {1'b0, small_q};
  assign k_last = ({1'b0, k_q} + 5'd1) >= {1'b0, ng_q};
  assign i_last = ({1'b0, i_q} + 5'd1) == {1'b0, ng_q};

  always_comb begin
    status_o.count_low    = r_q < 16'd2;
    status_o.grp_go       = grp_go;
    status_o.cur_le_small = cur_le_small;
    status_o.left_zero    = left_q == '0;
    status_o.cur_le_left  = cur_q <= left_q;
    status_o.k_last       = k_last;
    status_o.div_done     = div_done;
    status_o.i_last       = i_last;
  end

  // Select multiplier operands.
  always_comb begin
    mul_a = w_q;
    mul_b = r_q;
    case (op)
      hcpp_pkg::OP_MUL_CUR:   mul_b = {1'b0, gs};
      hcpp_pkg::OP_MUL_SMALL: begin
        mul_a = smallest_q;
        mul_b = {1'b0, gs};
      end
      default: ;
    endcase
  end
  assign mul_p = {16'b0, mul_a} * {27'b0, mul_b};

  // Select divider operands.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = left_q;
    div_divisor  = w_q >> j_q;
    case (op)
      hcpp_pkg::OP_DIV_LW: div_start = 1'b1;
      hcpp_pkg::OP_DIV_LS: begin
        div_start   = 1'b1;
        div_divisor = smallest_q;
      end
      hcpp_pkg::OP_DIV_T: begin
        div_start    = 1'b1;
        div_dividend = hcpp_pkg::ProdW'({16'b0, off_q} + span_q);
        div_divisor  = w_q;
      end
      default: ;
    endcase
  end

  hcpp_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Hold the smallest chunk size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smallest_q <= hcpp_pkg::SmallestReset;
    end else if (cfg_we_i) begin
      smallest_q <= cfg_data_i;
    end
  end

  // Advance the working registers.
  always_ff @(posedge clk_i) begin
    case (op)
      hcpp_pkg::OP_LOAD: begin
        r_q   <= region_count_i;
        w_q   <= region_words_i;
        cum_q <= '0;
        ng_q  <= '0;
      end
      hcpp_pkg::OP_MUL_TOT: total_q <= mul_p;
      hcpp_pkg::OP_MUL_CUR: begin
        cur_q   <= mul_p;
        span0_q <= mul_p;
      end
      hcpp_pkg::OP_MUL_SMALL: small_q <= mul_p[hcpp_pkg::SmallW-1:0];
      hcpp_pkg::OP_CG_STEP: begin
        ng_q  <= ng_q + 1'b1;
        cum_q <= cum_q + {1'b0, cur_q};
        if (!cur_le_small) cur_q <= cur_q >> 1;
      end
      hcpp_pkg::OP_CG_FIN: begin
        if ((cum_q < {1'b0, total_q}) && (ng_q < CapW) && !cur_le_small) begin
          ng_q <= ng_q + 1'b1;
        end
      end
      hcpp_pkg::OP_CC_INIT: begin
        left_q   <= total_q;
        cur_q    <= span0_q;
        chunks_q <= '0;
        k_q      <= '0;
        j_q      <= '0;
      end
      hcpp_pkg::OP_CC_SUB: begin
        left_q   <= left_q - cur_q;
        chunks_q <= chunks_q + {3'b0, gs};
        k_q      <= k_q + 1'b1;
        if (!k_last && !cur_le_small) begin
          cur_q <= cur_q >> 1;
          j_q   <= j_q + 1'b1;
        end
      end
      hcpp_pkg::OP_CC_ZERO: tc_q <= {25'b0, chunks_q};
      hcpp_pkg::OP_CC_SUM:  tc_q <= div_quot + {25'b0, chunks_q};
      hcpp_pkg::OP_EM_INIT: begin
        i_q      <= '0;
        region_q <= '0;
        off_q    <= '0;
        span_q   <= span0_q;
      end
      hcpp_pkg::OP_EMIT: i_q <= i_q + 1'b1;
      hcpp_pkg::OP_EM_UPD: begin
        region_q <= region_q + div_quot[hcpp_pkg::RegionCountW-1:0];
        off_q    <= div_rem;
        span_q   <= span_q >> 1;
      end
      default: ;
    endcase
  end

  // Drive the result strobe for one cycle per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (op == hcpp_pkg::OP_EMIT) || (op == hcpp_pkg::OP_EMIT_ERR);
    end
  end

  // Capture the result payload.
  always_ff @(posedge clk_i) begin
    if (op == hcpp_pkg::OP_EMIT) begin
      group_index_o        <= i_q[hcpp_pkg::IndexW-1:0];
      first_region_o       <= region_q;
      start_offset_words_o <= off_q[hcpp_pkg::OffsetW-1:0];
      chunk_words_o        <= w_q >> i_q;
      group_count_o        <= i_last ? ng_q : '0;
      total_chunks_o       <= i_last ? tc_q : '0;
      result_status_o      <= 1'b0;
      last_o               <= i_last;
    end else if (op == hcpp_pkg::OP_EMIT_ERR) begin
      group_index_o        <= '0;
      first_region_o       <= '0;
      start_offset_words_o <= '0;
      chunk_words_o        <= '0;
      group_count_o        <= '0;
      total_chunks_o       <= '0;
      result_status_o      <= 1'b1;
      last_o               <= 1'b1;
    end
  end

  assign valid_o = valid_q;

endmodule
`default_nettype wire

FILE: rtl/hcpp_ctrl.sv
// Controller: sequences loading, group counting, chunk counting and result emission.
`default_nettype none
module hcpp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire hcpp_pkg::dp_status_t status_i,
  output hcpp_pkg::dp_cmd_t         cmd_o
);

  hcpp_pkg::ctrl_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hcpp_pkg::ST_IDLE:      if (start_i) state_d = hcpp_pkg::ST_CHECK;
      hcpp_pkg::ST_CHECK:     state_d = status_i.count_low ? hcpp_pkg::ST_IDLE
                                                           : hcpp_pkg::ST_MUL_CUR;
      hcpp_pkg::ST_MUL_CUR:   state_d = hcpp_pkg::ST_MUL_SMALL;
      hcpp_pkg::ST_MUL_SMALL: state_d = hcpp_pkg::ST_GRP;
      hcpp_pkg::ST_GRP: begin
        if (!status_i.grp_go) state_d = hcpp_pkg::ST_CHK_INIT;
        else if (status_i.cur_le_small) state_d = hcpp_pkg::ST_GRP_FIN;
      end
      hcpp_pkg::ST_GRP_FIN:   state_d = hcpp_pkg::ST_CHK_INIT;
      hcpp_pkg::ST_CHK_INIT:  state_d = hcpp_pkg::ST_CHK;
      hcpp_pkg::ST_CHK: begin
        if (status_i.left_zero) state_d = hcpp_pkg::ST_EM_INIT;
        else if (!status_i.cur_le_left) state_d = hcpp_pkg::ST_CHK_WAIT;
        else if (status_i.k_last) state_d = hcpp_pkg::ST_CHK_DIVW;
        else if (status_i.cur_le_small) state_d = hcpp_pkg::ST_CHK_DIVS;
      end
      hcpp_pkg::ST_CHK_DIVW:  state_d = hcpp_pkg::ST_CHK_WAIT;
      hcpp_pkg::ST_CHK_DIVS:  state_d = hcpp_pkg::ST_CHK_WAIT;
      hcpp_pkg::ST_CHK_WAIT:  if (status_i.div_done) state_d = hcpp_pkg::ST_EM_INIT;
      hcpp_pkg::ST_EM_INIT:   state_d = hcpp_pkg::ST_EMIT;
      hcpp_pkg::ST_EMIT:      state_d = status_i.i_last ? hcpp_pkg::ST_IDLE
                                                        : hcpp_pkg::ST_EM_DIV;
      hcpp_pkg::ST_EM_DIV:    state_d = hcpp_pkg::ST_EM_WAIT;
      hcpp_pkg::ST_EM_WAIT:   if (status_i.div_done) state_d = hcpp_pkg::ST_EMIT;
      default:                state_d = hcpp_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o.op = hcpp_pkg::OP_NONE;
    unique case (state_q)
      hcpp_pkg::ST_IDLE:      if (start_i) cmd_o.op = hcpp_pkg::OP_LOAD;
      hcpp_pkg::ST_CHECK:     cmd_o.op = status_i.count_low ? hcpp_pkg::OP_EMIT_ERR
                                                            : hcpp_pkg::OP_MUL_TOT;
      hcpp_pkg::ST_MUL_CUR:   cmd_o.op = hcpp_pkg::OP_MUL_CUR;
      hcpp_pkg::ST_MUL_SMALL: cmd_o.op = hcpp_pkg::OP_MUL_SMALL;
      hcpp_pkg::ST_GRP:       cmd_o.op = status_i.grp_go ? hcpp_pkg::OP_CG_STEP
                                                         : hcpp_pkg::OP_CG_FIN;
      hcpp_pkg::ST_GRP_FIN:   cmd_o.op = hcpp_pkg::OP_CG_FIN;
      hcpp_pkg::ST_CHK_INIT:  cmd_o.op = hcpp_pkg::OP_CC_INIT;
      hcpp_pkg::ST_CHK: begin
        if (status_i.left_zero) cmd_o.op = hcpp_pkg::OP_CC_ZERO;
        else if (!status_i.cur_le_left) cmd_o.op = hcpp_pkg::OP_DIV_LW;
        else cmd_o.op = hcpp_pkg::OP_CC_SUB;
      end
      hcpp_pkg::ST_CHK_DIVW:  cmd_o.op = hcpp_pkg::OP_DIV_LW;
      hcpp_pkg::ST_CHK_DIVS:  cmd_o.op = hcpp_pkg::OP_DIV_LS;
      hcpp_pkg::ST_CHK_WAIT:  if (status_i.div_done) cmd_o.op = hcpp_pkg::OP_CC_SUM;
      hcpp_pkg::ST_EM_INIT:   cmd_o.op = hcpp_pkg::OP_EM_INIT;
      hcpp_pkg::ST_EMIT:      cmd_o.op = hcpp_pkg::OP_EMIT;
      hcpp_pkg::ST_EM_DIV:    cmd_o.op = hcpp_pkg::OP_DIV_T;
      hcpp_pkg::ST_EM_WAIT:   if (status_i.div_done) cmd_o.op = hcpp_pkg::OP_EM_UPD;
      default:                cmd_o.op = hcpp_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcpp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != hcpp_pkg::ST_IDLE;

endmodule
`default_nettype wire

FILE: rtl/halving_chunk_partition_planner.sv
// Top level: halving chunk partition planner, controller plus datapath.
//
// Usage: a request (region_count_i, region_words_i) is taken at a clock edge
// with start high and busy low. The block plans up to min(MAX_GROUPS, 8)
// groups and emits one result per group, each marked by valid_o for exactly
// one cycle; last_o marks the final result, which also carries group_count_o
// and total_chunks_o. A region count below two gives a single result with
// status_o set, on the ports once the check state has issued it and the
// result registers have captured it. Steps: setup (total, first span and
// smallest span products), group counting, chunk-count init, chunk counting,
// then, unless no words are left, a division of the words left, emission
// init and one emit step per group; each group after the first adds a
// division of its start position by the region size. One shared radix-2
// divider does every division. The final result appears as busy goes low,
// and one request is in flight at a time. Configuration: cfg_valid writes
// smallest_chunk_words (reset 4096); cfg_ready is always high; writes must be
// made only while the block is idle, which the block does not enforce.
// Reset: rst_ni clears the controller to idle and the register to its reset
// value; no result is pending after reset. The receiver cannot stall results.
`default_nettype none
module halving_chunk_partition_planner #(
  parameter int unsigned MAX_GROUPS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [hcpp_pkg::RegionCountW-1:0]   region_count_i,
  input  wire logic [hcpp_pkg::WordsW-1:0]         region_words_i,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hcpp_pkg::WordsW-1:0]         cfg_data_i,
  output logic                                     valid_o,
  output logic [hcpp_pkg::IndexW-1:0]              group_index_o,
  output logic [hcpp_pkg::RegionCountW-1:0]        first_region_o,
  output logic [hcpp_pkg::OffsetW-1:0]             start_offset_words_o,
  output logic [hcpp_pkg::WordsW-1:0]              chunk_words_o,
  output logic [hcpp_pkg::GroupW-1:0]              group_count_o,
  output logic [hcpp_pkg::TotalW-1:0]              total_chunks_o,
  output logic                                     status_o,
  output logic                                     last_o
);

  localparam int unsigned GroupCap =
    (MAX_GROUPS < hcpp_pkg::ResultSlots) ? MAX_GROUPS : hcpp_pkg::ResultSlots;

  hcpp_pkg::dp_cmd_t    cmd;
  hcpp_pkg::dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  hcpp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  hcpp_datapath #(
    .GroupCap (GroupCap)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (dp_status),
    .cfg_we_i             (cfg_valid && cfg_ready),
    .cfg_data_i           (cfg_data_i),
    .region_count_i       (region_count_i),
    .region_words_i       (region_words_i),
    .valid_o              (valid_o),
    .group_index_o        (group_index_o),
    .first_region_o       (first_region_o),
    .start_offset_words_o (start_offset_words_o),
    .chunk_words_o        (chunk_words_o),
    .group_count_o        (group_count_o),
    .total_chunks_o       (total_chunks_o),
    .result_status_o      (status_o),
    .last_o               (last_o)
  );

  // An error transaction is always the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o |-> last_o && (group_count_o == '0))
    else $error("error result not final");

  // An accepted request keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // More results must follow a non-final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("controller idle before final result");

  // Group count appears only on the final transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> (group_count_o == '0) && (total_chunks_o == '0))
    else $error("totals on non-final result");

endmodule
`default_nettype wire
